@@ sv/cci_pkg.sv @@
// Shared types and constants for the colour calibration and classification block.
`timescale 1ns / 1ps

package cci_pkg;

  // Width of raw frequencies and calibration points
  localparam int unsigned RawBits   = 20;
  // Width of a calibrated level; 255 < 2**LevelBits, so the quotient fits in LevelBits
  localparam int unsigned LevelBits = 8;
  localparam int unsigned DivSteps  = LevelBits;
  localparam int unsigned ThrBlackBits  = 8;
  localparam int unsigned ThrBrightBits = 10;
  localparam int unsigned SumBits   = LevelBits + 2;
  localparam int unsigned PaddrBits = 5;
  localparam int unsigned PdataBits = 32;
  localparam logic [LevelBits-1:0] FullScale = 8'd255;

  typedef enum logic [2:0] {
    CLASS_BLACK = 3'd0,
    CLASS_WHITE = 3'd1,
    CLASS_RED   = 3'd2,
    CLASS_GREEN = 3'd3,
    CLASS_BLUE  = 3'd4,
    CLASS_GRAY  = 3'd5
  } cci_class_e;

  typedef enum logic [2:0] {
    REG_DARK_RED    = 3'd0,
    REG_DARK_GREEN  = 3'd1,
    REG_DARK_BLUE   = 3'd2,
    REG_WHITE_RED   = 3'd3,
    REG_WHITE_GREEN = 3'd4,
    REG_WHITE_BLUE  = 3'd5,
    REG_BLACK_TH    = 3'd6,
    REG_BRIGHT_TH   = 3'd7
  } cci_reg_e;

  typedef struct packed {
    logic [RawBits-1:0] raw_red;
    logic [RawBits-1:0] raw_green;
    logic [RawBits-1:0] raw_blue;
  } cci_in_t;

  typedef struct packed {
    logic [LevelBits-1:0] level_red;
    logic [LevelBits-1:0] level_green;
    logic [LevelBits-1:0] level_blue;
    logic [2:0]           color_class;
    logic                 calibration_bad;
  } cci_out_t;

  typedef struct packed {
    logic [RawBits-1:0]       dark_red;
    logic [RawBits-1:0]       dark_green;
    logic [RawBits-1:0]       dark_blue;
    logic [RawBits-1:0]       white_red;
    logic [RawBits-1:0]       white_green;
    logic [RawBits-1:0]       white_blue;
    logic [ThrBlackBits-1:0]  black_threshold;
    logic [ThrBrightBits-1:0] bright_threshold;
  } cci_cfg_t;

  // Per-channel special cases, resolved at lane entry
  typedef struct packed {
    logic bad;   // white not above dark
    logic low;   // raw at or below dark
    logic high;  // raw at or above white
  } cci_flags_t;

endpackage

@@ sv/cci_regs.sv @@
// Configuration register bank behind the APB-style port.
`timescale 1ns / 1ps

module cci_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cci_pkg::PaddrBits-1:0]  paddr,
  input  logic [cci_pkg::PdataBits-1:0]  pwdata,
  output logic [cci_pkg::PdataBits-1:0]  prdata,
  output logic                           pready,
  output cci_pkg::cci_cfg_t              cfg_o
);
  import cci_pkg::*;

  cci_cfg_t cfg_q;
  cci_reg_e reg_idx;
  logic     wr_en;

  assign reg_idx = cci_reg_e'(paddr[PaddrBits-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register write, values truncated to the register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_red         <= RawBits'(4000);
      cfg_q.dark_green       <= RawBits'(4000);
      cfg_q.dark_blue        <= RawBits'(4000);
      cfg_q.white_red        <= RawBits'(50000);
      cfg_q.white_green      <= RawBits'(50000);
      cfg_q.white_blue       <= RawBits'(50000);
      cfg_q.black_threshold  <= ThrBlackBits'(30);
      cfg_q.bright_threshold <= ThrBrightBits'(700);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DARK_RED:    cfg_q.dark_red         <= pwdata[RawBits-1:0];
        REG_DARK_GREEN:  cfg_q.dark_green       <= pwdata[RawBits-1:0];
        REG_DARK_BLUE:   cfg_q.dark_blue        <= pwdata[RawBits-1:0];
        REG_WHITE_RED:   cfg_q.white_red        <= pwdata[RawBits-1:0];
        REG_WHITE_GREEN: cfg_q.white_green      <= pwdata[RawBits-1:0];
        REG_WHITE_BLUE:  cfg_q.white_blue       <= pwdata[RawBits-1:0];
        REG_BLACK_TH:    cfg_q.black_threshold  <= pwdata[ThrBlackBits-1:0];
        REG_BRIGHT_TH:   cfg_q.bright_threshold <= pwdata[ThrBrightBits-1:0];
        default:         cfg_q                  <= cfg_q;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (reg_idx)
      REG_DARK_RED:    prdata = PdataBits'(cfg_q.dark_red);
      REG_DARK_GREEN:  prdata = PdataBits'(cfg_q.dark_green);
      REG_DARK_BLUE:   prdata = PdataBits'(cfg_q.dark_blue);
      REG_WHITE_RED:   prdata = PdataBits'(cfg_q.white_red);
      REG_WHITE_GREEN: prdata = PdataBits'(cfg_q.white_green);
      REG_WHITE_BLUE:  prdata = PdataBits'(cfg_q.white_blue);
      REG_BLACK_TH:    prdata = PdataBits'(cfg_q.black_threshold);
      REG_BRIGHT_TH:   prdata = PdataBits'(cfg_q.bright_threshold);
      default:         prdata = '0;
    endcase
  end

endmodule

@@ sv/cci_lane.sv @@
// One calibration lane: entry stage plus a pipelined restoring divider.
`timescale 1ns / 1ps

module cci_lane (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [cci_pkg::RawBits-1:0]       raw_i,
  input  logic [cci_pkg::RawBits-1:0]       dark_i,
  input  logic [cci_pkg::RawBits-1:0]       white_i,
  output logic [cci_pkg::LevelBits-1:0]     level_o,
  output logic                              bad_o
);
  import cci_pkg::*;

  localparam int unsigned ProdBits = RawBits + LevelBits;
  localparam int unsigned Last     = DivSteps - 1;

  // Entry stage
  logic [RawBits-1:0] n0_q;
  logic [RawBits-1:0] den0_q;
  cci_flags_t         flg0_q;
  cci_flags_t         flg0_d;

  // Divider stages; remainder, dividend bits and divisor are not kept after the last step
  logic [RawBits-1:0]   rem_q  [Last];
  logic [LevelBits-1:0] bits_q [Last];
  logic [RawBits-1:0]   den_q  [Last];
  logic [LevelBits-1:0] quo_q  [DivSteps];
  cci_flags_t           flg_q  [DivSteps];

  logic [ProdBits-1:0]  prod;

  // Special cases: bad calibration, below dark, above white
  always_comb begin
    flg0_d.bad  = (white_i <= dark_i);
    flg0_d.low  = (raw_i <= dark_i);
    flg0_d.high = (raw_i >= white_i);
  end

  // Only meaningful when no flag is set, and then 0 < raw - dark < white - dark
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n0_q   <= raw_i - dark_i;
      den0_q <= white_i - dark_i;
      flg0_q <= flg0_d;
    end
  end

  // n * 255 as (n << 8) - n
  assign prod = {n0_q, {LevelBits{1'b0}}} - {{LevelBits{1'b0}}, n0_q};

  // One quotient bit per stage; the top part of prod is already below the divisor
  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [RawBits-1:0]   rem_in;
    logic [RawBits-1:0]   den_in;
    logic [LevelBits-1:0] bits_in;
    logic [LevelBits-1:0] quo_in;
    cci_flags_t           flg_in;
    logic [RawBits:0]     trial;
    logic [RawBits:0]     diff;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in  = prod[ProdBits-1:LevelBits];
      assign bits_in = prod[LevelBits-1:0];
      assign quo_in  = '0;
      assign den_in  = den0_q;
      assign flg_in  = flg0_q;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign bits_in = bits_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign flg_in  = flg_q[k-1];
    end

    assign trial = {rem_in, bits_in[LevelBits-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {quo_in[LevelBits-2:0], ge};
        flg_q[k] <= flg_in;
      end
    end

    if (k < Last) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k]  <= ge ? diff[RawBits-1:0] : trial[RawBits-1:0];
          bits_q[k] <= {bits_in[LevelBits-2:0], 1'b0};
          den_q[k]  <= den_in;
        end
      end
    end
  end

  // Clamp and special cases
  always_comb begin
    if (flg_q[Last].bad || flg_q[Last].low) begin
      level_o = '0;
    end else if (flg_q[Last].high) begin
      level_o = FullScale;
    end else begin
      level_o = quo_q[Last];
    end
  end

  assign bad_o = flg_q[Last].bad;

endmodule

@@ sv/cci_merge.sv @@
// Merging stage: channel sum, thresholds and dominant channel.
`timescale 1ns / 1ps

module cci_merge (
  input  logic [cci_pkg::LevelBits-1:0]     red_i,
  input  logic [cci_pkg::LevelBits-1:0]     green_i,
  input  logic [cci_pkg::LevelBits-1:0]     blue_i,
  input  logic [2:0]                        bad_i,
  input  logic [cci_pkg::ThrBlackBits-1:0]  black_th_i,
  input  logic [cci_pkg::ThrBrightBits-1:0] bright_th_i,
  output cci_pkg::cci_out_t                 res_o
);
  import cci_pkg::*;

  logic [SumBits-1:0] total;
  cci_class_e         cls;

  assign total = SumBits'(red_i) + SumBits'(green_i) + SumBits'(blue_i);

  // Black wins over white; then strictly largest channel, else gray
  always_comb begin
    if (total < SumBits'(black_th_i)) begin
      cls = CLASS_BLACK;
    end else if (total > SumBits'(bright_th_i)) begin
      cls = CLASS_WHITE;
    end else if (red_i > green_i && red_i > blue_i) begin
      cls = CLASS_RED;
    end else if (green_i > red_i && green_i > blue_i) begin
      cls = CLASS_GREEN;
    end else if (blue_i > red_i && blue_i > green_i) begin
      cls = CLASS_BLUE;
    end else begin
      cls = CLASS_GRAY;
    end
  end

  always_comb begin
    res_o.level_red       = red_i;
    res_o.level_green     = green_i;
    res_o.level_blue      = blue_i;
    res_o.color_class     = cls;
    res_o.calibration_bad = |bad_i;
  end

endmodule

@@ sv/color_calibrate_classify_top.sv @@
// Top level: two-point RGB calibration and colour classifier.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid_i / in_stall_o carry one cci_in_t per transfer
//   (raw red, green and blue frequencies). Output channel: out_valid_o /
//   out_stall_i carry one cci_out_t per input item, in input order; pready
//   is always high. The user must write registers via the APB-style port at
//   byte address 4*i only while no item is in flight (not enforced here).
// Pipeline and throughput
//   An input transfer loads the entry stage; the item then moves through
//   eight divider stages (one quotient bit each, in every channel's lane)
//   and then the output register, in that order.
//   One item is taken every cycle unless in_stall_o is high.
// Reset
//   rst_ni clears the pipeline and output valid bits and loads
//   the register defaults; nothing needs sweeping.
// Stalls
//   While the output is stalled the pipeline keeps filling; only once its
//   last stage holds an item that cannot leave does the whole pipeline
//   freeze and in_stall_o rise.
module color_calibrate_classify_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cci_pkg::cci_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cci_pkg::cci_out_t              out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cci_pkg::PaddrBits-1:0]  paddr,
  input  logic [cci_pkg::PdataBits-1:0]  pwdata,
  output logic [cci_pkg::PdataBits-1:0]  prdata,
  output logic                           pready
);
  import cci_pkg::*;

  // Entry stage plus divider stages
  localparam int unsigned Depth = DivSteps + 1;

  cci_cfg_t             cfg;
  logic [Depth-1:0]     vld_q;
  logic                 advance;
  logic                 out_load;
  logic                 out_valid_q;
  cci_out_t             out_data_q;
  cci_out_t             merged;
  logic [LevelBits-1:0] lvl_red;
  logic [LevelBits-1:0] lvl_green;
  logic [LevelBits-1:0] lvl_blue;
  logic [2:0]           bad;

  cci_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline moves unless its last item is blocked by a stalled output
  assign out_load   = vld_q[Depth-1] && (!out_valid_q || !out_stall_i);
  assign advance    = !(vld_q[Depth-1] && out_valid_q && out_stall_i);
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // Three lanes, one per colour channel
  cci_lane u_lane_red (
    .clk_i   (clk_i),
    .en_i    (advance),
    .raw_i   (in_data_i.raw_red),
    .dark_i  (cfg.dark_red),
    .white_i (cfg.white_red),
    .level_o (lvl_red),
    .bad_o   (bad[0])
  );

  cci_lane u_lane_green (
    .clk_i   (clk_i),
    .en_i    (advance),
    .raw_i   (in_data_i.raw_green),
    .dark_i  (cfg.dark_green),
    .white_i (cfg.white_green),
    .level_o (lvl_green),
    .bad_o   (bad[1])
  );

  cci_lane u_lane_blue (
    .clk_i   (clk_i),
    .en_i    (advance),
    .raw_i   (in_data_i.raw_blue),
    .dark_i  (cfg.dark_blue),
    .white_i (cfg.white_blue),
    .level_o (lvl_blue),
    .bad_o   (bad[2])
  );

  cci_merge u_merge (
    .red_i       (lvl_red),
    .green_i     (lvl_green),
    .blue_i      (lvl_blue),
    .bad_i       (bad),
    .black_th_i  (cfg.black_threshold),
    .bright_th_i (cfg.bright_threshold),
    .res_o       (merged)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= merged;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
